### rtl/vfop_pkg.sv
// ----------------------------------------------------------------------------
// vfop_pkg
// Shared types and constants of the voxel face occlusion packer: grid size,
// stream widths, command codes, controller states and the cell index function.
// ----------------------------------------------------------------------------
package vfop_pkg;

	// grid edge length in cells, 2 to 40
	localparam int GRID_SIZE = 16;
	localparam int CELLS     = GRID_SIZE * GRID_SIZE * GRID_SIZE;
	localparam int ADDR_W    = $clog2(CELLS);

	// stream widths
	localparam int S_TDATA_W = 80;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 96;
	localparam int M_TUSER_W = 2;

	// memory words
	localparam int FLAG_W  = 2;
	localparam int FLAG_OCC   = 0;
	localparam int FLAG_TRANS = 1;
	localparam int COLOR_W = 48;
	localparam int MAT_W   = 20;

	// neighbor coordinates are kept wide enough that x-1 at x=0 lands past the grid
	localparam int NB_W = 6;
	typedef logic [NB_W-1:0] nb_coord_t;
	localparam nb_coord_t GRID_LIM = NB_W'(GRID_SIZE);

	typedef logic [ADDR_W-1:0] cell_addr_t;
	typedef logic [2:0]        step_t;

	// query steps: the cell itself, then its six neighbors in mask bit order
	localparam step_t STEP_CENTER = 3'd0;
	localparam step_t STEP_XN     = 3'd1;
	localparam step_t STEP_YN     = 3'd2;
	localparam step_t STEP_ZN     = 3'd3;
	localparam step_t STEP_XP     = 3'd4;
	localparam step_t STEP_YP     = 3'd5;
	localparam step_t STEP_ZP     = 3'd6;

	localparam logic [5:0] MASK_ENCLOSED = 6'h3F;

	typedef enum logic [1:0] {
		CMD_PLACE = 2'd0,
		CMD_QUERY = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_e;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_PLACE,
		ST_QUERY,
		ST_EVAL,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic  latch;
		logic  sweep_wr;
		logic  place_wr;
		logic  rd;
		logic  out_load;
		step_t step;
	} ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic sweep_last;
		logic out_free;
	} stat_t;

	function automatic cell_addr_t cell_index(nb_coord_t x, nb_coord_t y, nb_coord_t z);
		return ADDR_W'(int'(x) + GRID_SIZE * (int'(y) + GRID_SIZE * int'(z)));
	endfunction

endpackage

### rtl/vfop_ram.sv
// ----------------------------------------------------------------------------
// vfop_ram
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module vfop_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/vfop_ctrl.sv
// ----------------------------------------------------------------------------
// vfop_ctrl
// Controller: takes requests, steps a query through the cell and its six
// neighbors, runs the grid clearing pass and hands results to the output slot.
// ----------------------------------------------------------------------------
module vfop_ctrl (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [vfop_pkg::S_TUSER_W-1:0]       s_tuser,
	input  vfop_pkg::stat_t                      stat,
	output vfop_pkg::ctrl_t                      ctrl
);
	import vfop_pkg::*;

	state_t state_q, state_d;
	step_t  step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			step_q  <= STEP_CENTER;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		s_tready = 1'b0;
		ctrl     = '0;
		ctrl.step = step_q;
		unique case (state_q)
			ST_SWEEP: begin
				ctrl.sweep_wr = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ctrl.latch = 1'b1;
					unique case (cmd_e'(s_tuser))
						CMD_PLACE: state_d = ST_PLACE;
						CMD_QUERY: state_d = ST_QUERY;
						CMD_CLEAR: state_d = ST_SWEEP;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_PLACE: begin
				ctrl.place_wr = 1'b1;
				state_d = ST_IDLE;
			end
			ST_QUERY: begin
				ctrl.rd = 1'b1;
				if (step_q == STEP_ZP) begin
					step_d  = STEP_CENTER;
					state_d = ST_EVAL;
				end else begin
					step_d = step_q + 3'd1;
				end
			end
			// last neighbor read lands in the mask here
			ST_EVAL: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					ctrl.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/vfop_dp.sv
// ----------------------------------------------------------------------------
// vfop_dp
// Datapath: request registers, grid memories, neighbor address generation,
// mask accumulation, clearing pass counter and the output register.
// ----------------------------------------------------------------------------
module vfop_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [vfop_pkg::S_TDATA_W-1:0]       s_tdata,
	input  vfop_pkg::ctrl_t                      ctrl,
	output vfop_pkg::stat_t                      stat,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [vfop_pkg::M_TDATA_W-1:0]       m_tdata,
	output logic [vfop_pkg::M_TUSER_W-1:0]       m_tuser
);
	import vfop_pkg::*;

	// request fields
	logic [3:0]  x_q, y_q, z_q;
	logic [23:0] diffuse_q, spec_q;
	logic [15:0] gloss_q;
	logic [2:0]  shader_q;
	logic        glow_q;

	always_ff @(posedge clk) begin
		if (ctrl.latch) begin
			x_q       <= s_tdata[3:0];
			y_q       <= s_tdata[7:4];
			z_q       <= s_tdata[11:8];
			diffuse_q <= s_tdata[35:12];
			spec_q    <= s_tdata[59:36];
			gloss_q   <= s_tdata[75:60];
			shader_q  <= s_tdata[78:76];
			glow_q    <= s_tdata[79];
		end
	end

	nb_coord_t  cx, cy, cz;
	cell_addr_t cen_idx;
	logic       cen_ok;

	assign cx      = NB_W'(x_q);
	assign cy      = NB_W'(y_q);
	assign cz      = NB_W'(z_q);
	assign cen_ok  = (cx < GRID_LIM) && (cy < GRID_LIM) && (cz < GRID_LIM);
	assign cen_idx = cell_index(cx, cy, cz);

	// neighbor address for the current step
	nb_coord_t  nx, ny, nz;
	cell_addr_t nb_idx;
	logic       nb_ok;

	always_comb begin
		nx = cx;
		ny = cy;
		nz = cz;
		unique case (ctrl.step)
			STEP_XN: nx = cx - NB_W'(1);
			STEP_YN: ny = cy - NB_W'(1);
			STEP_ZN: nz = cz - NB_W'(1);
			STEP_XP: nx = cx + NB_W'(1);
			STEP_YP: ny = cy + NB_W'(1);
			STEP_ZP: nz = cz + NB_W'(1);
			default: begin
			end
		endcase
	end

	assign nb_ok  = (nx < GRID_LIM) && (ny < GRID_LIM) && (nz < GRID_LIM);
	assign nb_idx = cell_index(nx, ny, nz);

	// clearing pass counter, wraps to zero at the last cell
	cell_addr_t sweep_q;

	assign stat.sweep_last = (sweep_q == ADDR_W'(CELLS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (ctrl.sweep_wr) begin
			sweep_q <= stat.sweep_last ? '0 : sweep_q + ADDR_W'(1);
		end
	end

	// occupied and transparent bits, cleared by the sweep
	logic              flag_we;
	cell_addr_t        flag_waddr;
	logic [FLAG_W-1:0] flag_wdata;
	logic [FLAG_W-1:0] flag_rd;

	assign flag_we    = ctrl.sweep_wr || (ctrl.place_wr && cen_ok);
	assign flag_waddr = ctrl.sweep_wr ? sweep_q : cen_idx;
	assign flag_wdata = ctrl.sweep_wr ? '0 : {shader_q != 3'd0, 1'b1};

	vfop_ram #(
		.WIDTH (FLAG_W),
		.DEPTH (CELLS)
	) u_flag_ram (
		.clk   (clk),
		.we    (flag_we),
		.waddr (flag_waddr),
		.wdata (flag_wdata),
		.re    (ctrl.rd && nb_ok),
		.raddr (nb_idx),
		.rdata (flag_rd)
	);

	logic              cen_rd;
	logic [COLOR_W-1:0] color_rd;
	logic [MAT_W-1:0]   mat_rd;

	assign cen_rd = ctrl.rd && nb_ok && (ctrl.step == STEP_CENTER);

	vfop_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (CELLS)
	) u_color_ram (
		.clk   (clk),
		.we    (ctrl.place_wr && cen_ok),
		.waddr (cen_idx),
		.wdata ({diffuse_q, spec_q}),
		.re    (cen_rd),
		.raddr (cen_idx),
		.rdata (color_rd)
	);

	vfop_ram #(
		.WIDTH (MAT_W),
		.DEPTH (CELLS)
	) u_mat_ram (
		.clk   (clk),
		.we    (ctrl.place_wr && cen_ok),
		.waddr (cen_idx),
		.wdata ({glow_q, shader_q, gloss_q}),
		.re    (cen_rd),
		.raddr (cen_idx),
		.rdata (mat_rd)
	);

	// read data comes back in the cycle after the address
	logic  rd_s1;
	logic  ok_s1;
	step_t step_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= ctrl.rd;
		end
	end

	always_ff @(posedge clk) begin
		ok_s1   <= nb_ok;
		step_s1 <= ctrl.step;
	end

	logic       cen_occ_q;
	logic       cen_trans_q;
	logic [5:0] mask_q;

	// opaque cells only see opaque neighbors, transparent cells see any
	always_ff @(posedge clk) begin
		if (rd_s1) begin
			if (step_s1 == STEP_CENTER) begin
				cen_occ_q   <= ok_s1 && flag_rd[FLAG_OCC];
				cen_trans_q <= flag_rd[FLAG_TRANS];
				mask_q      <= '0;
			end else if (ok_s1 && flag_rd[FLAG_OCC] && (cen_trans_q || !flag_rd[FLAG_TRANS])) begin
				mask_q <= mask_q | (6'd1 << (step_s1 - 3'd1));
			end
		end
	end

	// output slot
	logic                 visible;
	logic [31:0]          word_x, word_y, word_z;
	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [M_TUSER_W-1:0] m_tuser_q;

	assign visible = cen_occ_q && (mask_q != MASK_ENCLOSED);
	assign word_x  = {color_rd[47:32], 16'(cen_idx)};
	assign word_y  = {color_rd[23:0], color_rd[31:24]};
	assign word_z  = {mask_q, 6'd0, mat_rd};

	assign stat.out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			m_tdata_q <= visible ? {word_z, word_y, word_x} : '0;
			m_tuser_q <= {visible && cen_trans_q, visible};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

### rtl/voxel_face_occlusion_packer.sv
// ----------------------------------------------------------------------------
// voxel_face_occlusion_packer
// Voxel grid with neighbor face culling and packed instance word output.
// ----------------------------------------------------------------------------
// Holds a 16x16x16 voxel grid. A place request (tuser 0) stores a cube, and a
// clear request (tuser 2) sweeps the grid empty. A query (tuser 1) reads the
// cell and its six neighbors through the single read port of the occupancy
// memory, one cell per cycle; its result then goes into the output register,
// and waits if the previous result has not been taken. After reset the grid
// is swept empty while s_tready stays low. Each query gives one result;
// other requests give none.
module voxel_face_occlusion_packer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// pos_x, pos_y, pos_z, diffuse_rgb, specular_rgb, gloss_value, shader_kind, glow_flag
	input  logic [vfop_pkg::S_TDATA_W-1:0]       s_tdata,
	// cmd
	input  logic [vfop_pkg::S_TUSER_W-1:0]       s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// word_x, word_y, word_z
	output logic [vfop_pkg::M_TDATA_W-1:0]       m_tdata,
	// visible, is_transparent
	output logic [vfop_pkg::M_TUSER_W-1:0]       m_tuser
);
	import vfop_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	vfop_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	vfop_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.ctrl     (ctrl),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

`ifndef SYNTHESIS
	// no request taken while the grid is being cleared
	a_sweep_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.sweep_wr |-> !s_tready)
		else $error("request accepted during clearing pass");

	// a result never overwrites one still waiting
	a_load_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load |-> (!m_tvalid || m_tready))
		else $error("output slot overwritten");

	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctrl.sweep_wr, ctrl.place_wr, ctrl.rd, ctrl.out_load}))
		else $error("conflicting datapath commands");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.rd |-> (ctrl.step <= STEP_ZP))
		else $error("query step out of range");
`endif

endmodule
